[rtl/core/bole_pkg.sv]
// Package for the bounded ordered list engine.
// It holds the default parameter values, the field widths, and the command and status codes.
// It depends on nothing else.
`default_nettype none

package bole_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int LENGTH_W = 7;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;

endpackage

`default_nettype wire

[rtl/core/bole_store.sv]
// Element store of the list engine: one write port and one read port, read data registered.
// It depends on no package.
`default_nettype none

module bole_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic signed [WIDTH-1:0]  wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic signed [WIDTH-1:0]       rdata
);

    logic signed [WIDTH-1:0] mem [DEPTH];
    logic signed [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/bole_step.sv]
// Shared index stepper of the list engine: next index up or down and the end-of-walk compare.
// It depends on no package.
`default_nettype none

module bole_step #(
    parameter int LW = 5
) (
    input  wire logic [LW-1:0] idx,
    input  wire logic          dir,
    input  wire logic [LW-1:0] bound,
    output logic      [LW-1:0] nbr,
    output logic               hit
);

    // A downward walk stops when the index reaches the bound; an upward walk stops
    // when the next index would reach it.
    assign nbr = dir ? (idx - LW'(1)) : (idx + LW'(1));
    assign hit = ((dir ? idx : nbr) == bound);

endmodule

`default_nettype wire

[rtl/core/bounded_ordered_list_engine.sv]
// Bounded ordered list engine: top level with the command sequencer and the result register.
// Insert shifts the elements from the insert point up, then writes the word; delete fetches the
// word, then shifts the later elements down; search and dump walk the list. Output stalls can
// hold every result. A new command is taken only in idle, so one command is worked on at a time;
// each element takes a read state, then a write or check state, as the store read is registered.
// Reset clears the length and the handshake state; the store is not cleared. Uses bole_pkg.
`default_nettype none

module bounded_ordered_list_engine #(
    parameter int CAPACITY   = bole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bole_pkg::CMD_W-1:0]          command,
    input  wire logic signed [bole_pkg::VALUE_W-1:0] value,
    input  wire logic [bole_pkg::POS_W-1:0]          position,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [bole_pkg::STATUS_W-1:0]            status,
    output logic [bole_pkg::INDEX_W-1:0]             element_index,
    output logic signed [bole_pkg::VALUE_W-1:0]      element_value,
    output logic [bole_pkg::LENGTH_W-1:0]            list_length,
    output logic                                     last
);

    import bole_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_DEL_FETCH,
        S_DEL_HOLD,
        S_DEL_DONE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SRCH_END
    } state_t;

    state_t                  state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [DATA_WIDTH-1:0] word_reg, word_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [LW-1:0]           idx_reg, idx_next;
    logic [LW-1:0]           at_reg, at_next;
    logic                    dir_reg, dir_next;
    logic [LW-1:0]           len_reg, len_next;
    logic signed [DATA_WIDTH-1:0] del_word_reg, del_word_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [AW-1:0]           pend_idx_reg, pend_idx_next;
    logic signed [DATA_WIDTH-1:0] pend_val_reg, pend_val_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [INDEX_W-1:0]      index_reg, index_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [LENGTH_W-1:0]     length_reg, length_next;
    logic                    last_reg, last_next;

    logic                    emit;
    logic [STATUS_W-1:0]     e_status;
    logic [INDEX_W-1:0]      e_index;
    logic signed [VALUE_W-1:0] e_value;
    logic [LENGTH_W-1:0]     e_length;
    logic                    e_last;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic signed [DATA_WIDTH-1:0] mem_rdata;

    logic [LW-1:0]           step_nbr;
    logic                    step_hit;
    logic [LW-1:0]           step_bound;

    logic                    out_free;
    logic                    is_full;
    logic                    is_empty;
    logic                    bad_pos;
    logic                    match;

    bole_store #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign step_bound = dir_reg ? at_reg : len_reg;

    bole_step #(
        .LW (LW)
    ) u_step (
        .idx   (idx_reg),
        .dir   (dir_reg),
        .bound (step_bound),
        .nbr   (step_nbr),
        .hit   (step_hit)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_full   = (len_reg == LW'(CAPACITY));
    assign is_empty  = (len_reg == '0);
    assign bad_pos   = (pos_reg == '0) || (pos_reg > POS_W'(len_reg));
    assign match     = (mem_rdata == word_reg);
    assign mem_raddr = (state_reg == S_MV_RD) ? step_nbr[AW-1:0] : idx_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        dir_next        = dir_reg;
        len_next        = len_reg;
        del_word_next   = del_word_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_val_next   = pend_val_reg;

        emit     = 1'b0;
        e_status = ST_OK;
        e_index  = '0;
        e_value  = '0;
        e_length = LENGTH_W'(len_reg);
        e_last   = 1'b1;

        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    word_next  = DATA_WIDTH'(value);
                    pos_next   = position;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (cmd_reg)
                    CMD_INS_FRONT, CMD_INS_END, CMD_INS_AFTER:
                    begin
                        if (is_full || (cmd_reg == CMD_INS_AFTER && bad_pos))
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_status   = is_full ? ST_FULL : ST_BADPOS;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            if (cmd_reg == CMD_INS_FRONT)
                            begin
                                at_next = '0;
                            end
                            else if (cmd_reg == CMD_INS_END)
                            begin
                                at_next = len_reg;
                            end
                            else
                            begin
                                at_next = LW'(pos_reg);
                            end
                            idx_next   = len_reg;
                            dir_next   = 1'b1;
                            state_next = S_MV_RD;
                        end
                    end

                    CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS:
                    begin
                        if (is_empty || (cmd_reg == CMD_DEL_POS && bad_pos))
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_status   = is_empty ? ST_EMPTY : ST_BADPOS;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            if (cmd_reg == CMD_DEL_FRONT)
                            begin
                                idx_next = '0;
                            end
                            else if (cmd_reg == CMD_DEL_END)
                            begin
                                idx_next = len_reg - LW'(1);
                            end
                            else
                            begin
                                idx_next = LW'(pos_reg - POS_W'(1));
                            end
                            dir_next   = 1'b0;
                            state_next = S_DEL_FETCH;
                        end
                    end

                    default:
                    begin
                        if (is_empty)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next        = '0;
                            dir_next        = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN_RD;
                        end
                    end
                endcase
            end

            // Check for the end of the shift, otherwise fetch the neighbor to move.
            S_MV_RD:
            begin
                if (step_hit)
                begin
                    state_next = dir_reg ? S_PUT : S_DEL_DONE;
                end
                else
                begin
                    state_next = S_MV_WR;
                end
            end

            S_MV_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = step_nbr;
                state_next = S_MV_RD;
            end

            S_PUT:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = at_reg[AW-1:0];
                    mem_wdata  = word_reg;
                    len_next   = len_reg + LW'(1);
                    emit       = 1'b1;
                    e_status   = ST_OK;
                    e_length   = LENGTH_W'(len_reg + LW'(1));
                    state_next = S_IDLE;
                end
            end

            S_DEL_FETCH:
            begin
                state_next = S_DEL_HOLD;
            end

            S_DEL_HOLD:
            begin
                del_word_next = mem_rdata;
                state_next    = S_MV_RD;
            end

            S_DEL_DONE:
            begin
                if (out_free)
                begin
                    len_next   = len_reg - LW'(1);
                    emit       = 1'b1;
                    e_status   = ST_OK;
                    e_value    = VALUE_W'(del_word_reg);
                    e_length   = LENGTH_W'(len_reg - LW'(1));
                    state_next = S_IDLE;
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (cmd_reg == CMD_DUMP)
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        e_status = ST_OK;
                        e_index  = INDEX_W'(idx_reg);
                        e_value  = VALUE_W'(mem_rdata);
                        e_last   = step_hit;
                        if (step_hit)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = step_nbr;
                            state_next = S_SCAN_RD;
                        end
                    end
                end
                else if (!(match && pend_valid_reg && !out_free))
                begin
                    // A match is held back until the next one shows whether it is the last.
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit     = 1'b1;
                            e_status = ST_FOUND;
                            e_index  = INDEX_W'(pend_idx_reg);
                            e_value  = VALUE_W'(pend_val_reg);
                            e_last   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg[AW-1:0];
                        pend_val_next   = mem_rdata;
                    end
                    if (step_hit)
                    begin
                        state_next = S_SRCH_END;
                    end
                    else
                    begin
                        idx_next   = step_nbr;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SRCH_END:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        e_status = ST_FOUND;
                        e_index  = INDEX_W'(pend_idx_reg);
                        e_value  = VALUE_W'(pend_val_reg);
                    end
                    else
                    begin
                        e_status = ST_NOTFOUND;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = e_status;
            index_next     = e_index;
            value_next     = e_value;
            length_next    = e_length;
            last_next      = e_last;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
            status_next    = status_reg;
            index_next     = index_reg;
            value_next     = value_reg;
            length_next    = length_reg;
            last_next      = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_INS_FRONT;
            word_reg       <= '0;
            pos_reg        <= '0;
            idx_reg        <= '0;
            at_reg         <= '0;
            dir_reg        <= 1'b0;
            len_reg        <= '0;
            del_word_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            pend_val_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            index_reg      <= '0;
            value_reg      <= '0;
            length_reg     <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            word_reg       <= word_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            at_reg         <= at_next;
            dir_reg        <= dir_next;
            len_reg        <= len_next;
            del_word_reg   <= del_word_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            pend_val_reg   <= pend_val_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            index_reg      <= index_next;
            value_reg      <= value_next;
            length_reg     <= length_next;
            last_reg       <= last_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element_index = index_reg;
    assign element_value = value_reg;
    assign list_length   = length_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

[rtl/core/bole_checker.sv]
// Port-level checker for the bounded ordered list engine, with its bind to the top level.
// It depends on bole_pkg and on the port list of bounded_ordered_list_engine.
`default_nettype none

module bole_checker #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic [bole_pkg::CMD_W-1:0]          command,
    input wire logic signed [bole_pkg::VALUE_W-1:0] value,
    input wire logic [bole_pkg::POS_W-1:0]          position,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic [bole_pkg::STATUS_W-1:0]       status,
    input wire logic [bole_pkg::INDEX_W-1:0]        element_index,
    input wire logic signed [bole_pkg::VALUE_W-1:0] element_value,
    input wire logic [bole_pkg::LENGTH_W-1:0]       list_length,
    input wire logic                                last
);

    import bole_pkg::*;

    // A result that is held back by the receiver stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    // Every command keeps the engine busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("engine ready right after taking a command");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (list_length <= LENGTH_W'(CAPACITY)))
        else $error("reported length beyond capacity");

    // Error results carry no word and always close the command.
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY || status == ST_FULL ||
                       status == ST_BADPOS || status == ST_NOTFOUND))
        |-> (element_value == '0 && last))
        else $error("error result with a word or without last");

endmodule

bind bounded_ordered_list_engine bole_checker #(.CAPACITY(CAPACITY)) u_bole_checker (.*);

`default_nettype wire
